/* sv/cdgs_pkg.sv */
package cdgs_pkg;

  localparam int MaxNesting = 255;
  localparam int DepthW = $clog2(MaxNesting + 1);
  localparam int KwLen = 5;
  localparam int KwPosW = $clog2(KwLen + 1);

  typedef logic [DepthW-1:0] depth_t;
  typedef logic [KwPosW-1:0] kw_pos_t;

  typedef enum logic [1:0] {
    VerdictUndecided = 2'd0,
    VerdictAccept    = 2'd1,
    VerdictReject    = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    PhKeyword = 2'b01,
    PhBody    = 2'b10
  } phase_t;

  typedef enum logic [6:0] {
    SkNormal    = 7'b0000001,
    SkBs        = 7'b0000010,
    SkBsCr      = 7'b0000100,
    SkSlash     = 7'b0001000,
    SkLine      = 7'b0010000,
    SkBlock     = 7'b0100000,
    SkBlockStar = 7'b1000000
  } skip_t;

  typedef enum logic [2:0] {
    StrOut = 3'b001,
    StrIn  = 3'b010,
    StrEsc = 3'b100
  } str_t;

  localparam logic [7:0] ChEnd       = 8'h00;
  localparam logic [7:0] ChSemi      = 8'h3B;
  localparam logic [7:0] ChLBrace    = 8'h7B;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChNl        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;

  function automatic logic [7:0] kw_letter(input kw_pos_t idx);
    logic [7:0] r;
    case (idx)
      kw_pos_t'(0): r = 8'h63;
      kw_pos_t'(1): r = 8'h6C;
      kw_pos_t'(2): r = 8'h61;
      default:      r = 8'h73;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
           c == 8'h0C || c == 8'h0B;
  endfunction

endpackage

/* sv/cdgs_ifs.sv */
interface cdgs_req_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic       guard_allowed;
  logic [7:0] character;

  modport source (output valid, start_req, guard_allowed, character, input ready);
  modport sink (input valid, start_req, guard_allowed, character, output ready);
endinterface

interface cdgs_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

/* sv/class_declaration_guard_scanner_unit.sv */
// Scans a byte stream, one byte per item, for a class declaration guard: optional
// whitespace, continuations and comments, the keyword "class" in any letter case,
// then tokens up to a semicolon outside parentheses (verdict 1) or a brace outside
// parentheses, end of input (byte 0), a mismatch or a start without guard_allowed
// (verdict 2). Every item yields exactly one result; verdict 0 means undecided. A
// verdict holds until an item with start_req set. The block takes one item per clock
// cycle unless rsp.ready stalls the result; each result is offered after its item
// passes the input register, then the result register fed by the scanner state update.
module class_declaration_guard_scanner_unit (
  input logic clk,
  input logic rst,
  cdgs_req_if.sink   req,
  cdgs_rsp_if.source rsp
);

  logic       s1_valid;
  logic       s1_start;
  logic       s1_guard;
  logic [7:0] s1_char;
  logic       advance;

  cdgs_pkg::phase_t   phase, phase_next;
  cdgs_pkg::kw_pos_t  kw_pos, kw_pos_next;
  cdgs_pkg::skip_t    skip, skip_next;
  cdgs_pkg::str_t     str, str_next;
  cdgs_pkg::depth_t   depth, depth_next;
  cdgs_pkg::verdict_t decision, decision_next;

  logic       out_valid;
  logic [1:0] out_verdict;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.verdict = out_verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_start <= req.start_req;
      s1_guard <= req.guard_allowed;
      s1_char  <= req.character;
    end
  end

  always_comb begin
    logic done;
    logic tok;
    logic [7:0] c;
    c             = s1_char;
    phase_next    = phase;
    kw_pos_next   = kw_pos;
    skip_next     = skip;
    str_next      = str;
    depth_next    = depth;
    decision_next = decision;
    done          = 1'b0;
    tok           = 1'b0;
    if (s1_start) begin
      phase_next    = cdgs_pkg::PhKeyword;
      kw_pos_next   = '0;
      skip_next     = cdgs_pkg::SkNormal;
      str_next      = cdgs_pkg::StrOut;
      depth_next    = '0;
      decision_next = s1_guard ? cdgs_pkg::VerdictUndecided : cdgs_pkg::VerdictReject;
    end
    if (decision_next == cdgs_pkg::VerdictUndecided) begin
      if (phase_next == cdgs_pkg::PhKeyword && kw_pos_next != '0) begin
        if (kw_pos_next < cdgs_pkg::kw_pos_t'(cdgs_pkg::KwLen)) begin
          if (cdgs_pkg::fold(c) == cdgs_pkg::kw_letter(kw_pos_next)) begin
            kw_pos_next = kw_pos_next + 1'b1;
          end else begin
            decision_next = cdgs_pkg::VerdictReject;
          end
          done = 1'b1;
        end else if (cdgs_pkg::is_word(c)) begin
          decision_next = cdgs_pkg::VerdictReject;
          done = 1'b1;
        end else begin
          phase_next = cdgs_pkg::PhBody;
          skip_next  = cdgs_pkg::SkNormal;
        end
      end
      if (!done && phase_next == cdgs_pkg::PhBody && str_next != cdgs_pkg::StrOut) begin
        done = 1'b1;
        if (c == cdgs_pkg::ChEnd) begin
          decision_next = cdgs_pkg::VerdictReject;
        end else if (str_next == cdgs_pkg::StrEsc) begin
          str_next = cdgs_pkg::StrIn;
        end else if (c == cdgs_pkg::ChBackslash) begin
          str_next = cdgs_pkg::StrEsc;
        end else if (c == cdgs_pkg::ChQuote) begin
          str_next = cdgs_pkg::StrOut;
        end
      end
      if (!done) begin
        unique case (skip_next)
          cdgs_pkg::SkNormal: begin
            if (cdgs_pkg::is_space(c)) begin
              tok = 1'b0;
            end else if (c == cdgs_pkg::ChBackslash) begin
              skip_next = cdgs_pkg::SkBs;
            end else if (c == cdgs_pkg::ChSlash) begin
              skip_next = cdgs_pkg::SkSlash;
            end else begin
              tok = 1'b1;
            end
          end
          cdgs_pkg::SkBs: begin
            if (c == cdgs_pkg::ChCr) begin
              skip_next = cdgs_pkg::SkBsCr;
            end else if (c == cdgs_pkg::ChNl) begin
              skip_next = cdgs_pkg::SkNormal;
            end else if (c == cdgs_pkg::ChSlash) begin
              skip_next = cdgs_pkg::SkSlash;
            end else begin
              skip_next = cdgs_pkg::SkNormal;
              tok = 1'b1;
            end
          end
          cdgs_pkg::SkBsCr: begin
            if (c == cdgs_pkg::ChNl) begin
              skip_next = cdgs_pkg::SkNormal;
            end else if (c == cdgs_pkg::ChSlash) begin
              skip_next = cdgs_pkg::SkSlash;
            end else begin
              skip_next = cdgs_pkg::SkNormal;
              tok = 1'b1;
            end
          end
          cdgs_pkg::SkSlash: begin
            if (c == cdgs_pkg::ChSlash) begin
              skip_next = cdgs_pkg::SkLine;
            end else if (c == cdgs_pkg::ChStar) begin
              skip_next = cdgs_pkg::SkBlock;
            end else begin
              skip_next = cdgs_pkg::SkNormal;
              tok = 1'b1;
            end
          end
          cdgs_pkg::SkLine: begin
            if (c == cdgs_pkg::ChEnd) begin
              skip_next = cdgs_pkg::SkNormal;
              tok = 1'b1;
            end else if (c == cdgs_pkg::ChNl) begin
              skip_next = cdgs_pkg::SkNormal;
            end
          end
          cdgs_pkg::SkBlock: begin
            if (c == cdgs_pkg::ChEnd) begin
              skip_next = cdgs_pkg::SkNormal;
              tok = 1'b1;
            end else if (c == cdgs_pkg::ChStar) begin
              skip_next = cdgs_pkg::SkBlockStar;
            end
          end
          cdgs_pkg::SkBlockStar: begin
            if (c == cdgs_pkg::ChEnd) begin
              skip_next = cdgs_pkg::SkNormal;
              tok = 1'b1;
            end else if (c == cdgs_pkg::ChSlash) begin
              skip_next = cdgs_pkg::SkNormal;
            end else if (c != cdgs_pkg::ChStar) begin
              skip_next = cdgs_pkg::SkBlock;
            end
          end
          default: begin
            skip_next = cdgs_pkg::SkNormal;
            tok = 1'b1;
          end
        endcase
        if (tok) begin
          if (phase_next == cdgs_pkg::PhKeyword) begin
            if (cdgs_pkg::fold(c) == cdgs_pkg::kw_letter('0)) begin
              kw_pos_next = cdgs_pkg::kw_pos_t'(1);
            end else begin
              decision_next = cdgs_pkg::VerdictReject;
            end
          end else if (c == cdgs_pkg::ChEnd) begin
            decision_next = cdgs_pkg::VerdictReject;
          end else if (c == cdgs_pkg::ChQuote) begin
            str_next = cdgs_pkg::StrIn;
          end else if (c == cdgs_pkg::ChLParen) begin
            if (depth_next < cdgs_pkg::depth_t'(cdgs_pkg::MaxNesting)) begin
              depth_next = depth_next + 1'b1;
            end
          end else if (c == cdgs_pkg::ChRParen) begin
            if (depth_next != '0) begin
              depth_next = depth_next - 1'b1;
            end
          end else if (depth_next == '0) begin
            if (c == cdgs_pkg::ChSemi) begin
              decision_next = cdgs_pkg::VerdictAccept;
            end else if (c == cdgs_pkg::ChLBrace) begin
              decision_next = cdgs_pkg::VerdictReject;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= cdgs_pkg::PhKeyword;
      kw_pos    <= '0;
      skip      <= cdgs_pkg::SkNormal;
      str       <= cdgs_pkg::StrOut;
      depth     <= '0;
      decision  <= cdgs_pkg::VerdictUndecided;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        phase    <= phase_next;
        kw_pos   <= kw_pos_next;
        skip     <= skip_next;
        str      <= str_next;
        depth    <= depth_next;
        decision <= decision_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_verdict <= decision_next;
    end
  end

  a_verdict_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && !s1_start && decision != cdgs_pkg::VerdictUndecided)
      |-> decision_next == decision)
    else $error("verdict changed without a start");

  a_guard_blocked: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && s1_start && !s1_guard)
      |=> out_valid && out_verdict == cdgs_pkg::VerdictReject)
    else $error("disallowed guard not rejected");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= cdgs_pkg::depth_t'(cdgs_pkg::MaxNesting))
    else $error("nesting depth above limit");

  a_body_after_kw: assert property (@(posedge clk) disable iff (rst)
    phase == cdgs_pkg::PhBody |-> kw_pos == cdgs_pkg::kw_pos_t'(cdgs_pkg::KwLen))
    else $error("body phase without full keyword");

  a_kw_bound: assert property (@(posedge clk) disable iff (rst)
    kw_pos <= cdgs_pkg::kw_pos_t'(cdgs_pkg::KwLen))
    else $error("keyword position out of range");

endmodule
